// File: rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// prl_pkg
// Shared types and constants for the polygon region lookup block.
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int LON_W     = 26;
    localparam int LAT_W     = 25;
    localparam int SLOT_W    = 12;
    localparam int ENTRY_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int CFG_W     = 6;
    localparam int IDX_W     = 5;
    localparam int S_DATA_W  = 144;
    localparam int M_DATA_W  = 8;
    localparam int DIFF_W    = 27;
    localparam int PROD_W    = 54;
    localparam int MIN_RING_VERTICES = 3;

    localparam logic [1:0] CMD_VERTEX = 2'd0;
    localparam logic [1:0] CMD_RING   = 2'd1;
    localparam logic [1:0] CMD_REGION = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [2:0] ADDR_REGIONS_IN_USE = 3'd0;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_REG_RD   = 11'b000_0000_0010,
        ST_REG_CHK  = 11'b000_0000_0100,
        ST_RING_RD  = 11'b000_0000_1000,
        ST_RING_CHK = 11'b000_0001_0000,
        ST_V_PREV   = 11'b000_0010_0000,
        ST_V_CUR    = 11'b000_0100_0000,
        ST_MUL1     = 11'b000_1000_0000,
        ST_MUL2     = 11'b001_0000_0000,
        ST_CMP      = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } state_t;

endpackage

// File: rtl/prl_ram.sv
// ----------------------------------------------------------------------------
// prl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module prl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/polygon_region_lookup.sv
// ----------------------------------------------------------------------------
// polygon_region_lookup
// Point-in-region search over polygons with holes, one shared multiplier.
// ----------------------------------------------------------------------------
// requests arrive on s_t*; cmd travels in s_tuser, all other fields in s_tdata
// load requests write the vertex, ring or region table; a rejected load
// reports load_error and writes nothing
// query requests test regions 0 .. min(regions_in_use, MAX_REGIONS)-1 in
// order and return the first region whose box and an outer ring hold the point
// and no hole holds it; rings under 3 vertices hold no point
// one result per request on m_t*, held in an output register
// a load passes from idle to the done state; a query reads and checks each
// region, then for a region whose box holds the point reads and checks each
// ring and walks its edges on the shared multiplier (two products and one
// compare per edge)
// s_tready is high only while the sequencer is idle
// a stalled result holds the sequencer until m_tready takes it
// reset clears the control state and regions_in_use; tables hold no reset
// value; the user must write them before reading; the block does not check
// regions_in_use is written over the APB port at byte address 0
// ----------------------------------------------------------------------------
module polygon_region_lookup #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_RINGS    = 256,
    parameter int MAX_REGIONS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // slot, lon_e5, lat_e5, box_max_lon, box_max_lat, first_entry,
    // entry_count, is_hole, zero fill
    input  logic [prl_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found, region_index, load_error, zero fill
    output logic [prl_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int RW  = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int GW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int GCW = $clog2(MAX_REGIONS + 1);
    localparam int LON_W = prl_pkg::LON_W;
    localparam int LAT_W = prl_pkg::LAT_W;
    localparam int V_W   = LON_W + LAT_W;
    localparam int RING_W = VW + (VW + 1) + 1;
    localparam int BOX_W  = 2 * LON_W + 2 * LAT_W;
    localparam int REGM_W = BOX_W + RW + (RW + 1);

    // request fields
    logic [11:0]       in_slot;
    logic [LON_W-1:0]  in_lon;
    logic [LAT_W-1:0]  in_lat;
    logic [LON_W-1:0]  in_max_lon;
    logic [LAT_W-1:0]  in_max_lat;
    logic [11:0]       in_first;
    logic [12:0]       in_count;
    logic              in_hole;

    assign in_slot    = s_tdata[11:0];
    assign in_lon     = s_tdata[37:12];
    assign in_lat     = s_tdata[62:38];
    assign in_max_lon = s_tdata[88:63];
    assign in_max_lat = s_tdata[113:89];
    assign in_first   = s_tdata[125:114];
    assign in_count   = s_tdata[138:126];
    assign in_hole    = s_tdata[139];

    // configuration
    logic [prl_pkg::CFG_W-1:0] regions_in_use_reg;
    logic                      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == prl_pkg::ADDR_REGIONS_IN_USE);
    assign prdata    = (paddr == prl_pkg::ADDR_REGIONS_IN_USE) ?
                       {{(32 - prl_pkg::CFG_W){1'b0}}, regions_in_use_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_in_use_reg <= '0;
        end
        else if (cfg_write)
        begin
            regions_in_use_reg <= pwdata[prl_pkg::CFG_W-1:0];
        end
    end

    // sequencer registers
    prl_pkg::state_t   state_reg, state_next;
    logic [LON_W-1:0]  px_reg, px_next;
    logic [LAT_W-1:0]  py_reg, py_next;
    logic [GCW-1:0]    g_reg, g_next;
    logic [RW-1:0]     ring_reg, ring_next;
    logic [RW:0]       rc_reg, rc_next;
    logic [VW-1:0]     cur_reg, cur_next;
    logic [VW:0]       rem_reg, rem_next;
    logic              outer_reg, outer_next;
    logic              inside_reg, inside_next;
    logic              hole_reg, hole_next;
    logic [V_W-1:0]    a_reg, a_next;
    logic [V_W-1:0]    b_reg, b_next;
    logic              cond_reg, cond_next;
    logic              dpos_reg, dpos_next;
    logic signed [prl_pkg::PROD_W-1:0] lhs_reg, lhs_next;
    logic signed [prl_pkg::PROD_W-1:0] rhs_reg, rhs_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [prl_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic              err_reg, err_next;
    logic              res_found_reg, res_found_next;
    logic [prl_pkg::IDX_W-1:0] res_idx_reg, res_idx_next;
    logic              res_err_reg, res_err_next;

    // memories
    logic              v_we, r_we, g_we;
    logic [VW-1:0]     v_waddr, v_raddr;
    logic [RW-1:0]     r_waddr;
    logic [GW-1:0]     g_waddr, g_raddr;
    logic [V_W-1:0]    v_wdata, v_rdata;
    logic [RING_W-1:0] r_wdata, r_rdata;
    logic [REGM_W-1:0] g_wdata, g_rdata;

    prl_ram #(.WIDTH(V_W), .DEPTH(MAX_VERTICES), .AW(VW)) u_vertex_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    prl_ram #(.WIDTH(RING_W), .DEPTH(MAX_RINGS), .AW(RW)) u_ring_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (ring_reg),
        .rdata (r_rdata)
    );

    prl_ram #(.WIDTH(REGM_W), .DEPTH(MAX_REGIONS), .AW(GW)) u_region_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // load checks
    logic        accept;
    logic [31:0] slot32, first32, count32, span32;
    logic        v_err, r_err, g_err;

    assign s_tready = (state_reg == prl_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign slot32   = {20'd0, in_slot};
    assign first32  = {20'd0, in_first};
    assign count32  = {19'd0, in_count};
    assign span32   = first32 + count32;
    assign v_err    = slot32 >= 32'(MAX_VERTICES);
    assign r_err    = (slot32 >= 32'(MAX_RINGS)) || (span32 > 32'(MAX_VERTICES));
    assign g_err    = (slot32 >= 32'(MAX_REGIONS)) || (span32 > 32'(MAX_RINGS));

    assign v_we    = accept && (s_tuser == prl_pkg::CMD_VERTEX) && !v_err;
    assign r_we    = accept && (s_tuser == prl_pkg::CMD_RING) && !r_err;
    assign g_we    = accept && (s_tuser == prl_pkg::CMD_REGION) && !g_err;
    assign v_waddr = slot32[VW-1:0];
    assign r_waddr = slot32[RW-1:0];
    assign g_waddr = slot32[GW-1:0];
    assign v_wdata = {in_lat, in_lon};
    assign r_wdata = {in_hole, count32[VW:0], first32[VW-1:0]};
    assign g_wdata = {count32[RW:0], first32[RW-1:0],
                      in_max_lat, in_max_lon, in_lat, in_lon};

    // table read fields
    logic signed [LON_W-1:0] box_min_lon, box_max_lon;
    logic signed [LAT_W-1:0] box_min_lat, box_max_lat;
    logic [RW-1:0]           reg_first;
    logic [RW:0]             reg_total;
    logic [VW-1:0]           ring_start;
    logic [VW:0]             ring_len;
    logic                    ring_hole;
    logic [VW:0]             prev_sum;
    logic [31:0]             g32;
    logic [31:0]             n32;

    assign box_min_lon = g_rdata[LON_W-1:0];
    assign box_min_lat = g_rdata[V_W-1:LON_W];
    assign box_max_lon = g_rdata[V_W+LON_W-1:V_W];
    assign box_max_lat = g_rdata[BOX_W-1:V_W+LON_W];
    assign reg_first   = g_rdata[BOX_W+RW-1:BOX_W];
    assign reg_total   = g_rdata[REGM_W-1:BOX_W+RW];
    assign ring_start  = r_rdata[VW-1:0];
    assign ring_len    = r_rdata[2*VW:VW];
    assign ring_hole   = r_rdata[RING_W-1];
    assign prev_sum    = {1'b0, ring_start} + ring_len - {{VW{1'b0}}, 1'b1};
    assign g32         = {{(32 - GCW){1'b0}}, g_reg};
    assign n32         = ({26'd0, regions_in_use_reg} > 32'(MAX_REGIONS)) ?
                         32'(MAX_REGIONS) : {26'd0, regions_in_use_reg};
    assign g_raddr     = g32[GW-1:0];

    always_comb
    begin
        case (state_reg)
            prl_pkg::ST_RING_CHK: v_raddr = prev_sum[VW-1:0];
            prl_pkg::ST_CMP:      v_raddr = cur_reg + {{(VW-1){1'b0}}, 1'b1};
            default:              v_raddr = cur_reg;
        endcase
    end

    // shared multiplier
    logic signed [LON_W-1:0] a_lon, b_lon, p_lon;
    logic signed [LAT_W-1:0] a_lat, b_lat, p_lat;
    logic signed [prl_pkg::DIFF_W-1:0] mul_a, mul_b;
    logic signed [prl_pkg::PROD_W-1:0] prod;

    assign a_lon = a_reg[LON_W-1:0];
    assign a_lat = a_reg[V_W-1:LON_W];
    assign b_lon = b_reg[LON_W-1:0];
    assign b_lat = b_reg[V_W-1:LON_W];
    assign p_lon = px_reg;
    assign p_lat = py_reg;

    always_comb
    begin
        if (state_reg == prl_pkg::ST_MUL1)
        begin
            mul_a = {p_lon[LON_W-1], p_lon} - {a_lon[LON_W-1], a_lon};
            mul_b = {{2{b_lat[LAT_W-1]}}, b_lat} - {{2{a_lat[LAT_W-1]}}, a_lat};
        end
        else
        begin
            mul_a = {b_lon[LON_W-1], b_lon} - {a_lon[LON_W-1], a_lon};
            mul_b = {{2{p_lat[LAT_W-1]}}, p_lat} - {{2{a_lat[LAT_W-1]}}, a_lat};
        end
    end

    assign prod = mul_a * mul_b;

    // ring completion
    logic ring_fin;
    logic ring_in;
    logic edge_left;
    logic box_in;

    assign edge_left = dpos_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg);
    assign box_in    = !($signed(px_reg) < box_min_lon) && !($signed(px_reg) > box_max_lon) &&
                       !($signed(py_reg) < box_min_lat) && !($signed(py_reg) > box_max_lat);

    always_comb
    begin
        ring_fin = 1'b0;
        ring_in  = 1'b0;
        if (state_reg == prl_pkg::ST_RING_CHK)
        begin
            ring_fin = ({{(31 - VW){1'b0}}, ring_len} < 32'(prl_pkg::MIN_RING_VERTICES));
        end
        else if (state_reg == prl_pkg::ST_CMP)
        begin
            ring_fin = (rem_reg == {{VW{1'b0}}, 1'b1});
            ring_in  = inside_reg ^ (cond_reg && edge_left);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        g_next         = g_reg;
        ring_next      = ring_reg;
        rc_next        = rc_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        outer_next     = outer_reg;
        inside_next    = inside_reg;
        hole_next      = hole_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cond_next      = cond_reg;
        dpos_next      = dpos_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_err_next   = res_err_reg;

        case (state_reg)
            prl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    px_next    = in_lon;
                    py_next    = in_lat;
                    found_next = 1'b0;
                    idx_next   = '0;
                    g_next     = '0;
                    case (s_tuser)
                        prl_pkg::CMD_VERTEX: err_next = v_err;
                        prl_pkg::CMD_RING:   err_next = r_err;
                        prl_pkg::CMD_REGION: err_next = g_err;
                        default:             err_next = 1'b0;
                    endcase
                    state_next = (s_tuser == prl_pkg::CMD_QUERY) ?
                                 prl_pkg::ST_REG_RD : prl_pkg::ST_DONE;
                end
            end
            prl_pkg::ST_REG_RD:
            begin
                state_next = (g32 >= n32) ? prl_pkg::ST_DONE : prl_pkg::ST_REG_CHK;
            end
            prl_pkg::ST_REG_CHK:
            begin
                if (box_in && (reg_total != '0))
                begin
                    ring_next  = reg_first;
                    rc_next    = reg_total;
                    outer_next = 1'b0;
                    state_next = prl_pkg::ST_RING_RD;
                end
                else
                begin
                    g_next     = g_reg + {{(GCW-1){1'b0}}, 1'b1};
                    state_next = prl_pkg::ST_REG_RD;
                end
            end
            prl_pkg::ST_RING_RD:
            begin
                state_next = prl_pkg::ST_RING_CHK;
            end
            prl_pkg::ST_RING_CHK:
            begin
                cur_next    = ring_start;
                rem_next    = ring_len;
                inside_next = 1'b0;
                hole_next   = ring_hole;
                state_next  = prl_pkg::ST_V_PREV;
            end
            prl_pkg::ST_V_PREV:
            begin
                b_next     = v_rdata;
                state_next = prl_pkg::ST_V_CUR;
            end
            prl_pkg::ST_V_CUR:
            begin
                a_next     = v_rdata;
                state_next = prl_pkg::ST_MUL1;
            end
            prl_pkg::ST_MUL1:
            begin
                lhs_next   = prod;
                cond_next  = (a_lat > p_lat) != (b_lat > p_lat);
                dpos_next  = b_lat > a_lat;
                state_next = prl_pkg::ST_MUL2;
            end
            prl_pkg::ST_MUL2:
            begin
                rhs_next   = prod;
                state_next = prl_pkg::ST_CMP;
            end
            prl_pkg::ST_CMP:
            begin
                inside_next = ring_in;
                b_next      = a_reg;
                rem_next    = rem_reg - {{VW{1'b0}}, 1'b1};
                cur_next    = cur_reg + {{(VW-1){1'b0}}, 1'b1};
                state_next  = prl_pkg::ST_V_CUR;
            end
            prl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    res_found_next = found_reg;
                    res_idx_next   = idx_reg;
                    res_err_next   = err_reg;
                    state_next     = prl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prl_pkg::ST_IDLE;
            end
        endcase

        // ring end: hole hit or last ring ends the region, else next ring
        if (ring_fin)
        begin
            if (ring_in && (state_reg == prl_pkg::ST_CMP ? hole_reg : ring_hole))
            begin
                g_next     = g_reg + {{(GCW-1){1'b0}}, 1'b1};
                state_next = prl_pkg::ST_REG_RD;
            end
            else if (rc_reg == {{RW{1'b0}}, 1'b1})
            begin
                if (outer_reg || ring_in)
                begin
                    found_next = 1'b1;
                    idx_next   = g32[prl_pkg::IDX_W-1:0];
                    state_next = prl_pkg::ST_DONE;
                end
                else
                begin
                    g_next     = g_reg + {{(GCW-1){1'b0}}, 1'b1};
                    state_next = prl_pkg::ST_REG_RD;
                end
            end
            else
            begin
                outer_next = outer_reg || ring_in;
                ring_next  = ring_reg + {{(RW-1){1'b0}}, 1'b1};
                rc_next    = rc_reg - {{RW{1'b0}}, 1'b1};
                state_next = prl_pkg::ST_RING_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        g_reg         <= g_next;
        ring_reg      <= ring_next;
        rc_reg        <= rc_next;
        cur_reg       <= cur_next;
        rem_reg       <= rem_next;
        outer_reg     <= outer_next;
        inside_reg    <= inside_next;
        hole_reg      <= hole_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        cond_reg      <= cond_next;
        dpos_reg      <= dpos_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        err_reg       <= err_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_err_reg   <= res_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, res_err_reg, res_idx_reg, res_found_reg};

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// polygon region lookup testbench
// Loads vertex, ring and region tables through the request stream, queries
// points around the loaded polygons and checks every result against an
// in-bench predictor, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_VERT  = 4096;
    localparam int NUM_RING  = 256;
    localparam int NUM_REG   = 32;
    localparam int LIMIT     = 3000000;
    localparam int SPAN      = 3000;

    typedef struct {
        logic [1:0]                        cmd;
        logic [prl_pkg::SLOT_W-1:0]        slot;
        logic signed [prl_pkg::LON_W-1:0]  lon;
        logic signed [prl_pkg::LAT_W-1:0]  lat;
        logic signed [prl_pkg::LON_W-1:0]  max_lon;
        logic signed [prl_pkg::LAT_W-1:0]  max_lat;
        logic [prl_pkg::ENTRY_W-1:0]       first;
        logic [prl_pkg::COUNT_W-1:0]       count;
        logic                              hole;
    } request_t;

    typedef struct {
        logic                      found;
        logic [prl_pkg::IDX_W-1:0] index;
        logic                      err;
    } answer_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [prl_pkg::S_DATA_W-1:0]   s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [prl_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [2:0]                     paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    request_t pending_q[$];
    answer_t  answer_q[$];
    int       errors;
    int       cycles;
    bit       quiet;
    bit       req_taken;
    int       send_gap;
    int       stall_gap;

    // predictor state
    longint      vert_lon[NUM_VERT];
    longint      vert_lat[NUM_VERT];
    int unsigned ring_first[NUM_RING];
    int unsigned ring_len[NUM_RING];
    bit          ring_is_hole[NUM_RING];
    longint      box_lo_lon[NUM_REG];
    longint      box_lo_lat[NUM_REG];
    longint      box_hi_lon[NUM_REG];
    longint      box_hi_lat[NUM_REG];
    int unsigned reg_first[NUM_REG];
    int unsigned reg_total[NUM_REG];
    int unsigned regions_in_use;

    polygon_region_lookup u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("polygon_region_lookup test failed");
            $finish;
        end
    end

    function automatic bit ring_holds(int unsigned r, longint px, longint py);
        int unsigned s;
        int unsigned n;
        int unsigned prv;
        int unsigned cur;
        longint ax, ay, bx, by, d, lhs, rhs;
        bit odd;
        bit left;
        s = ring_first[r];
        n = ring_len[r];
        odd = 1'b0;
        if (n < 3 || s + n > NUM_VERT)
            return 1'b0;
        prv = s + n - 1;
        for (int unsigned k = 0; k < n; k++)
        begin
            cur = s + k;
            ax = vert_lon[cur];
            ay = vert_lat[cur];
            bx = vert_lon[prv];
            by = vert_lat[prv];
            if ((ay > py) != (by > py))
            begin
                d = by - ay;
                lhs = (px - ax) * d;
                rhs = (bx - ax) * (py - ay);
                left = (d > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    odd = !odd;
            end
            prv = cur;
        end
        return odd;
    endfunction

    function automatic bit region_holds(int unsigned g, longint px, longint py);
        bit outer;
        outer = 1'b0;
        if (px < box_lo_lon[g] || px > box_hi_lon[g] ||
            py < box_lo_lat[g] || py > box_hi_lat[g])
            return 1'b0;
        for (int unsigned r = reg_first[g];
             r < reg_first[g] + reg_total[g] && r < NUM_RING; r++)
        begin
            if (ring_holds(r, px, py))
            begin
                if (ring_is_hole[r])
                    return 1'b0;
                outer = 1'b1;
            end
        end
        return outer;
    endfunction

    // applies one request to the predictor tables and returns its result
    function automatic answer_t lookup_apply(request_t q);
        answer_t a;
        int unsigned n;
        a.found = 1'b0;
        a.index = '0;
        a.err = 1'b0;
        case (q.cmd)
            prl_pkg::CMD_VERTEX:
            begin
                vert_lon[q.slot] = q.lon;
                vert_lat[q.slot] = q.lat;
            end
            prl_pkg::CMD_RING:
            begin
                if (q.slot >= NUM_RING || int'(q.first) + int'(q.count) > NUM_VERT)
                    a.err = 1'b1;
                else
                begin
                    ring_first[q.slot] = q.first;
                    ring_len[q.slot] = q.count;
                    ring_is_hole[q.slot] = q.hole;
                end
            end
            prl_pkg::CMD_REGION:
            begin
                if (q.slot >= NUM_REG || int'(q.first) + int'(q.count) > NUM_RING)
                    a.err = 1'b1;
                else
                begin
                    box_lo_lon[q.slot] = q.lon;
                    box_lo_lat[q.slot] = q.lat;
                    box_hi_lon[q.slot] = q.max_lon;
                    box_hi_lat[q.slot] = q.max_lat;
                    reg_first[q.slot] = q.first;
                    reg_total[q.slot] = q.count;
                end
            end
            default:
            begin
                n = (regions_in_use > NUM_REG) ? NUM_REG : regions_in_use;
                for (int unsigned g = 0; g < n; g++)
                begin
                    if (region_holds(g, q.lon, q.lat))
                    begin
                        a.found = 1'b1;
                        a.index = g[prl_pkg::IDX_W-1:0];
                        break;
                    end
                end
            end
        endcase
        return a;
    endfunction

    task automatic report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    // driver: requests and result back-pressure change on the falling edge
    always @(negedge clk)
    begin
        request_t q;
        logic v;
        logic rdy;
        v = s_tvalid;
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                v = 1'b0;
                if (send_gap > 0)
                    send_gap--;
                else if (pending_q.size() > 0)
                begin
                    q = pending_q.pop_front();
                    v = 1'b1;
                    s_tuser <= q.cmd;
                    s_tdata <= {4'b0, q.hole, q.count, q.first, q.max_lat, q.max_lon,
                                q.lat, q.lon, q.slot};
                    if (!quiet && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 12);
                end
            end
            rdy = 1'b1;
            if (stall_gap > 0)
            begin
                stall_gap--;
                rdy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
                stall_gap = $urandom_range(1, 12);
            m_tready <= rdy;
        end
        s_tvalid <= v;
    end

    // monitor: predict on request acceptance, check on result acceptance
    always @(posedge clk)
    begin
        request_t q;
        answer_t want;
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                    report($sformatf("unexpected result %h", m_tdata));
                else
                begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.found)
                        report($sformatf("found %b want %b", m_tdata[0], want.found));
                    if (m_tdata[5:1] !== want.index)
                        report($sformatf("region_index %0d want %0d",
                                         m_tdata[5:1], want.index));
                    if (m_tdata[6] !== want.err)
                        report($sformatf("load_error %b want %b", m_tdata[6], want.err));
                end
            end
            if (s_tvalid && s_tready)
            begin
                took = 1'b1;
                {q.hole, q.count, q.first, q.max_lat, q.max_lon, q.lat, q.lon, q.slot}
                    = s_tdata[139:0];
                q.cmd = s_tuser;
                answer_q.push_back(lookup_apply(q));
            end
        end
        req_taken <= took;
    end

    function automatic request_t make_req(logic [1:0] cmd, int slot, int lon, int lat,
                                          int max_lon, int max_lat, int first,
                                          int count, bit hole);
        request_t q;
        q.cmd = cmd;
        q.slot = slot[prl_pkg::SLOT_W-1:0];
        q.lon = lon[prl_pkg::LON_W-1:0];
        q.lat = lat[prl_pkg::LAT_W-1:0];
        q.max_lon = max_lon[prl_pkg::LON_W-1:0];
        q.max_lat = max_lat[prl_pkg::LAT_W-1:0];
        q.first = first[prl_pkg::ENTRY_W-1:0];
        q.count = count[prl_pkg::COUNT_W-1:0];
        q.hole = hole;
        return q;
    endfunction

    function automatic int around(int c, int r);
        return c + int'($urandom_range(0, 2 * r)) - r;
    endfunction

    task automatic wait_idle();
        while (pending_q.size() > 0 || answer_q.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(int unsigned value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= prl_pkg::ADDR_REGIONS_IN_USE;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        regions_in_use = value & 32'h3F;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[prl_pkg::CFG_W-1:0] !== regions_in_use[prl_pkg::CFG_W-1:0])
            report($sformatf("regions_in_use read %0d want %0d", prdata, regions_in_use));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_ring(int slot);
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
        pending_q.push_back(make_req(prl_pkg::CMD_RING, slot, 0, 0, 0, 0,
                                     $urandom_range(0, 17), n,
                                     $urandom_range(0, 3) == 0));
    endtask

    task automatic random_region(int slot, int c_lon, int c_lat);
        int f;
        int lo_lon, lo_lat, hi_lon, hi_lat;
        f = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
        begin
            lo_lon = around(c_lon, SPAN);
            lo_lat = around(c_lat, SPAN);
            hi_lon = around(c_lon, SPAN);
            hi_lat = around(c_lat, SPAN);
        end
        else
        begin
            lo_lon = c_lon - SPAN;
            lo_lat = c_lat - SPAN;
            hi_lon = c_lon + SPAN;
            hi_lat = c_lat + SPAN;
        end
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, slot, lo_lon, lo_lat, hi_lon,
                                     hi_lat, f,
                                     $urandom_range(0, (8 - f < 4) ? 8 - f : 4),
                                     $urandom_range(0, 1)));
    endtask

    initial
    begin
        int c_lon;
        int c_lat;
        int pick;
        int unsigned settings[4];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = prl_pkg::CMD_VERTEX;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        req_taken = 1'b0;
        send_gap = 0;
        stall_gap = 0;
        regions_in_use = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: no regions searched, rejected loads, field extremes
        apb_write(0);
        pending_q.push_back(make_req(prl_pkg::CMD_QUERY, 4095, -18000000, -9000000,
                                     18000000, 9000000, 4095, 8191, 1));
        pending_q.push_back(make_req(prl_pkg::CMD_QUERY, 0, 18000000, 9000000,
                                     0, 0, 0, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_QUERY, 0, -33554432, -16777216,
                                     -33554432, -16777216, 0, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_QUERY, 0, 33554431, 16777215,
                                     33554431, 16777215, 0, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_VERTEX, 4095, -18000000, 9000000,
                                     0, 0, 0, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_VERTEX, 4094, 33554431, -16777216,
                                     0, 0, 0, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 256, 0, 0, 0, 0, 0, 3, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 4095, 0, 0, 0, 0, 0, 3, 1));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 10, 0, 0, 0, 0, 4095, 2, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 11, 0, 0, 0, 0, 0, 8191, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 255, 0, 0, 0, 0, 0, 4096, 1));
        pending_q.push_back(make_req(prl_pkg::CMD_RING, 254, 0, 0, 0, 0, 4095, 1, 1));
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, 32, 0, 0, 0, 0, 0, 1, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, 4095, 0, 0, 0, 0, 0, 1, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, 5, 0, 0, 0, 0, 200, 57, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, 6, 0, 0, 0, 0, 4095, 0, 0));
        pending_q.push_back(make_req(prl_pkg::CMD_REGION, 31, -18000000, -9000000,
                                     18000000, 9000000, 0, 256, 0));
        wait_idle();

        // tables: 24 vertices, 8 rings and every region around one centre
        c_lon = int'($urandom_range(0, 35980000)) - 17990000;
        c_lat = int'($urandom_range(0, 17980000)) - 8990000;
        for (int i = 0; i < 24; i++)
            pending_q.push_back(make_req(prl_pkg::CMD_VERTEX, i, around(c_lon, SPAN),
                                         around(c_lat, SPAN), 0, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            random_ring(i);
        for (int i = 0; i < NUM_REG; i++)
            random_region(i, c_lon, c_lat);
        wait_idle();

        settings[0] = 32;
        settings[1] = $urandom_range(1, 31);
        settings[2] = 63;
        settings[3] = 1;
        for (int p = 0; p < 4; p++)
        begin
            apb_write(settings[p]);
            quiet = (p == 3);
            for (int i = 0; i < 15; i++)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    pending_q.push_back(make_req(prl_pkg::CMD_QUERY, $urandom_range(0, 4095),
                                                 around(c_lon, SPAN + 500),
                                                 around(c_lat, SPAN + 500),
                                                 0, 0, 0, 0, 0));
                else if (pick == 12)
                    pending_q.push_back(make_req(prl_pkg::CMD_QUERY, 0, $urandom, $urandom,
                                                 $urandom, $urandom, $urandom, $urandom,
                                                 $urandom));
                else if (pick < 15)
                    pending_q.push_back(make_req(prl_pkg::CMD_VERTEX, $urandom_range(0, 23),
                                                 around(c_lon, SPAN), around(c_lat, SPAN),
                                                 0, 0, 0, 0, 0));
                else if (pick == 15)
                    random_ring($urandom_range(0, 7));
                else if (pick == 16)
                    random_region($urandom_range(0, 31), c_lon, c_lat);
                else if (pick == 17)
                    pending_q.push_back(make_req(prl_pkg::CMD_RING, $urandom_range(256, 4095),
                                                 0, 0, 0, 0, 0, 3, 0));
                else if (pick == 18)
                    pending_q.push_back(make_req(prl_pkg::CMD_RING, $urandom_range(0, 255),
                                                 0, 0, 0, 0, $urandom_range(3000, 4095),
                                                 $urandom_range(1100, 8191), 0));
                else
                    pending_q.push_back(make_req(prl_pkg::CMD_REGION,
                                                 $urandom_range(0, 4095), 0, 0,
                                                 0, 0, $urandom_range(250, 4095),
                                                 $urandom_range(7, 8191), 0));
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("polygon_region_lookup test passed");
        else
            $display("polygon_region_lookup test failed");
        $finish;
    end

endmodule
